[sv/stx_etx_frame_checker_lrc_defines.svh]
// Assertion macros for the STX/ETX frame checker.
// Used by the top level only; no other dependencies.
`ifndef STX_ETX_FRAME_CHECKER_LRC_DEFINES_SVH
`define STX_ETX_FRAME_CHECKER_LRC_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SEFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SEFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sefc_pkg.sv]
// Package for the STX/ETX frame checker: field widths, marker bytes, codes.
// No dependencies.
`default_nettype none

package sefc_pkg;

   localparam int MAX_BURST_DEFAULT = 1024;

   localparam int BYTE_W        = 8;
   localparam int REPLY_W       = 2;
   localparam int COUNT_W       = 2;
   localparam int FRAME_START_W = 10;
   localparam int FRAME_LEN_W   = 11;
   localparam int MODE_W        = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = MODE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEST_MODE  = 1'd1;

   localparam logic [BYTE_W-1:0] STX_BYTE = 8'h02;
   localparam logic [BYTE_W-1:0] ETX_BYTE = 8'h03;

   localparam logic [REPLY_W-1:0] REPLY_NONE = 2'd0;
   localparam logic [REPLY_W-1:0] REPLY_ACK  = 2'd1;
   localparam logic [REPLY_W-1:0] REPLY_NAK  = 2'd2;

   localparam logic [MODE_W-1:0] FRAME_PLAIN = 2'd0;
   localparam logic [MODE_W-1:0] FRAME_LRC   = 2'd1;

   localparam logic [MODE_W-1:0] TEST_NO_REPLY   = 2'd1;
   localparam logic [MODE_W-1:0] TEST_ALWAYS_NAK = 2'd2;

   localparam logic [COUNT_W-1:0] ACKS_PLAIN = 2'd1;
   localparam logic [COUNT_W-1:0] ACKS_LRC   = 2'd2;

endpackage

`default_nettype wire

[sv/sefc_if.sv]
// Valid/ready channel interfaces for the STX/ETX frame checker.
// Depends on sefc_pkg for the field widths.
`default_nettype none

interface sefc_req_if;
   logic                            valid;
   logic                            ready;
   logic [sefc_pkg::BYTE_W-1:0]     rx_byte;
   logic                            end_of_burst;

   modport source (output valid, output rx_byte, output end_of_burst, input ready);
   modport sink   (input valid, input rx_byte, input end_of_burst, output ready);
endinterface

interface sefc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sefc_pkg::REPLY_W-1:0]       reply;
   logic [sefc_pkg::COUNT_W-1:0]       reply_count;
   logic [sefc_pkg::COUNT_W-1:0]       expected_acks;
   logic [sefc_pkg::FRAME_START_W-1:0] frame_start;
   logic [sefc_pkg::FRAME_LEN_W-1:0]   frame_length;

   modport source (output valid, output reply, output reply_count, output expected_acks,
                   output frame_start, output frame_length, input ready);
   modport sink   (input valid, input reply, input reply_count, input expected_acks,
                   input frame_start, input frame_length, output ready);
endinterface

`default_nettype wire

[sv/stx_etx_frame_checker_lrc.sv]
// STX/ETX burst frame checker with optional XOR LRC, top level.
// Depends on sefc_pkg, sefc_if.sv and stx_etx_frame_checker_lrc_defines.svh.
//
// Takes one received byte per item on req_ch, end_of_burst set on the last byte,
// and returns one verdict item on rsp_ch per burst (none for the other bytes):
// ACK, NAK or no reply, the reply character count, the acks awaited afterwards,
// and the offset and length of the frame (both 0 unless ACK). A byte is taken
// every unstalled cycle; the verdict sits in the result register the cycle after the
// last byte is accepted. Throughput is one item per clock, bounded only by the
// single result register: req_ch.ready is low only while a verdict waits and
// rsp_ch.ready is low. Each byte just updates the running positions and XOR
// values, so the path from the state registers to the result register is one
// byte compare, one XOR and a short position subtract. Bursts longer than
// MAX_BURST bytes are counted but otherwise ignored and answer NAK. Mode
// registers are written through csr_we/csr_index/csr_wdata and should only be
// changed while no burst is in flight.
`default_nettype none
`include "stx_etx_frame_checker_lrc_defines.svh"

module stx_etx_frame_checker_lrc #(
   parameter int MAX_BURST = sefc_pkg::MAX_BURST_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sefc_req_if.sink                               req_ch,
   sefc_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [sefc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sefc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // position counter saturates at MAX_BURST+1; marks live below MAX_BURST
   localparam int POS_W = $clog2(MAX_BURST + 2);
   localparam int IDX_W = $clog2(MAX_BURST);

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BURST);

   typedef enum logic [1:0] {
      SCAN_SEARCHING,
      SCAN_END_SEEN,
      SCAN_DONE
   } scan_type;

   typedef logic [sefc_pkg::BYTE_W-1:0] byte_type;

   // config
   logic [sefc_pkg::MODE_W-1:0] frame_mode_ff, test_mode_ff;

   // per-burst state
   logic [POS_W-1:0] pos_ff, pos_in;
   byte_type         first_ff, first_in;
   byte_type         prev_ff, prev_in;
   logic [IDX_W-1:0] stx_pos_ff, stx_pos_in;
   logic             stx_seen_ff, stx_seen_in;
   logic [IDX_W-1:0] etx_pos_ff, etx_pos_in;
   scan_type         scan_ff, scan_in;
   byte_type         check_ff, check_in;
   byte_type         xfs_ff, xfs_in;       // xor of bytes 1..current
   byte_type         xbl_ff, xbl_in;       // xor of bytes 1..previous
   byte_type         xas_ff, xas_in;       // xor after last STX through ETX

   logic [sefc_pkg::COUNT_W-1:0] ack_ff, ack_in;

   // result register
   logic                                rsp_valid_ff;
   logic [sefc_pkg::REPLY_W-1:0]        reply_ff, reply_in;
   logic [sefc_pkg::COUNT_W-1:0]        reply_count_ff, reply_count_in;
   logic [sefc_pkg::COUNT_W-1:0]        exp_acks_ff;
   logic [sefc_pkg::FRAME_START_W-1:0]  start_ff, start_in;
   logic [sefc_pkg::FRAME_LEN_W-1:0]    length_ff, length_in;

   // values after this byte, before the end-of-burst clear
   logic [POS_W-1:0] upd_pos;
   byte_type         upd_first, upd_prev, upd_check, upd_xfs, upd_xbl, upd_xas;
   logic [IDX_W-1:0] upd_stx_pos, upd_etx_pos;
   logic             upd_stx_seen;
   scan_type         upd_scan;

   logic             req_acc, last_acc, in_range, ok;
   byte_type         b;
   logic [POS_W-1:0] stx_pos_ext, etx_pos_ext, frame_start_pos, frame_len;
   logic [POS_W+sefc_pkg::FRAME_LEN_W-1:0]   len_wide;
   logic [POS_W+sefc_pkg::FRAME_START_W-1:0] start_wide;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign last_acc     = req_acc && req_ch.end_of_burst;
   assign b            = req_ch.rx_byte;

   // running scan update for one byte
   always_comb begin
      upd_pos      = pos_ff;
      upd_first    = first_ff;
      upd_prev     = prev_ff;
      upd_stx_pos  = stx_pos_ff;
      upd_stx_seen = stx_seen_ff;
      upd_etx_pos  = etx_pos_ff;
      upd_scan     = scan_ff;
      upd_check    = check_ff;
      upd_xfs      = xfs_ff;
      upd_xbl      = xbl_ff;
      upd_xas      = xas_ff;
      if (pos_ff < POS_MAX) begin
         if (pos_ff == '0) begin
            upd_first = b;
         end else begin
            upd_xbl = xfs_ff;
            upd_xfs = xfs_ff ^ b;
         end
         unique case (scan_ff)
            SCAN_SEARCHING: begin
               if (b == sefc_pkg::STX_BYTE) begin
                  upd_stx_seen = 1'b1;
                  upd_stx_pos  = pos_ff[IDX_W-1:0];
                  upd_xas      = '0;
               end else begin
                  upd_xas = xas_ff ^ b;
                  if (b == sefc_pkg::ETX_BYTE) begin
                     upd_etx_pos = pos_ff[IDX_W-1:0];
                     upd_scan    = SCAN_END_SEEN;
                  end
               end
            end
            SCAN_END_SEEN: begin
               upd_check = b;
               upd_scan  = SCAN_DONE;
            end
            default: begin
            end
         endcase
         upd_prev = b;
      end
      if (pos_ff <= POS_MAX) begin
         upd_pos = pos_ff + POS_W'(1);
      end
   end

   // verdict on the last byte
   always_comb begin
      ok              = 1'b0;
      ack_in          = ack_ff;
      reply_in        = sefc_pkg::REPLY_NAK;
      stx_pos_ext     = POS_W'(upd_stx_pos);
      etx_pos_ext     = POS_W'(upd_etx_pos);
      frame_start_pos = '0;
      frame_len       = '0;
      in_range        = (upd_pos >= POS_W'(2)) && (upd_pos <= POS_MAX);
      priority if (test_mode_ff == sefc_pkg::TEST_NO_REPLY) begin
         reply_in = sefc_pkg::REPLY_NONE;
      end else if (test_mode_ff == sefc_pkg::TEST_ALWAYS_NAK
                   || frame_mode_ff > sefc_pkg::FRAME_LRC) begin
         reply_in = sefc_pkg::REPLY_NAK;
      end else begin
         ack_in = (frame_mode_ff == sefc_pkg::FRAME_PLAIN) ? sefc_pkg::ACKS_PLAIN
                                                           : sefc_pkg::ACKS_LRC;
         if (in_range) begin
            if (frame_mode_ff == sefc_pkg::FRAME_PLAIN) begin
               // whole burst is the frame, else last STX before first ETX
               if (upd_first == sefc_pkg::STX_BYTE && b == sefc_pkg::ETX_BYTE) begin
                  ok        = 1'b1;
                  frame_len = upd_pos;
               end else if (upd_stx_seen && upd_scan != SCAN_SEARCHING) begin
                  ok              = 1'b1;
                  frame_start_pos = stx_pos_ext;
                  frame_len       = etx_pos_ext - stx_pos_ext + POS_W'(1);
               end
            end else begin
               // ETX second to last: LRC is the current byte
               if (upd_first == sefc_pkg::STX_BYTE && prev_ff == sefc_pkg::ETX_BYTE) begin
                  ok        = (upd_xbl == b);
                  frame_len = upd_pos;
               end else if (upd_stx_seen && upd_scan == SCAN_DONE) begin
                  ok              = (upd_xas == upd_check);
                  frame_start_pos = stx_pos_ext;
                  frame_len       = etx_pos_ext - stx_pos_ext + POS_W'(2);
               end
            end
         end
         reply_in = ok ? sefc_pkg::REPLY_ACK : sefc_pkg::REPLY_NAK;
      end
      if (!ok) begin
         frame_start_pos = '0;
         frame_len       = '0;
      end
      reply_count_in = (reply_in == sefc_pkg::REPLY_NONE) ? '0 : ack_in;
      start_wide     = {{sefc_pkg::FRAME_START_W{1'b0}}, frame_start_pos};
      len_wide       = {{sefc_pkg::FRAME_LEN_W{1'b0}}, frame_len};
      start_in       = start_wide[sefc_pkg::FRAME_START_W-1:0];
      length_in      = len_wide[sefc_pkg::FRAME_LEN_W-1:0];
   end

   // next state: burst state clears after the last byte
   always_comb begin
      pos_in      = pos_ff;
      first_in    = first_ff;
      prev_in     = prev_ff;
      stx_pos_in  = stx_pos_ff;
      stx_seen_in = stx_seen_ff;
      etx_pos_in  = etx_pos_ff;
      scan_in     = scan_ff;
      check_in    = check_ff;
      xfs_in      = xfs_ff;
      xbl_in      = xbl_ff;
      xas_in      = xas_ff;
      if (last_acc) begin
         pos_in      = '0;
         first_in    = '0;
         prev_in     = '0;
         stx_pos_in  = '0;
         stx_seen_in = 1'b0;
         etx_pos_in  = '0;
         scan_in     = SCAN_SEARCHING;
         check_in    = '0;
         xfs_in      = '0;
         xbl_in      = '0;
         xas_in      = '0;
      end else if (req_acc) begin
         pos_in      = upd_pos;
         first_in    = upd_first;
         prev_in     = upd_prev;
         stx_pos_in  = upd_stx_pos;
         stx_seen_in = upd_stx_seen;
         etx_pos_in  = upd_etx_pos;
         scan_in     = upd_scan;
         check_in    = upd_check;
         xfs_in      = upd_xfs;
         xbl_in      = upd_xbl;
         xas_in      = upd_xas;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= '0;
         test_mode_ff  <= '0;
         pos_ff        <= '0;
         first_ff      <= '0;
         prev_ff       <= '0;
         stx_pos_ff    <= '0;
         stx_seen_ff   <= 1'b0;
         etx_pos_ff    <= '0;
         scan_ff       <= SCAN_SEARCHING;
         check_ff      <= '0;
         xfs_ff        <= '0;
         xbl_ff        <= '0;
         xas_ff        <= '0;
         ack_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_index == sefc_pkg::REG_FRAME_MODE) begin
            frame_mode_ff <= csr_wdata;
         end
         if (csr_we && csr_index == sefc_pkg::REG_TEST_MODE) begin
            test_mode_ff <= csr_wdata;
         end
         pos_ff      <= pos_in;
         first_ff    <= first_in;
         prev_ff     <= prev_in;
         stx_pos_ff  <= stx_pos_in;
         stx_seen_ff <= stx_seen_in;
         etx_pos_ff  <= etx_pos_in;
         scan_ff     <= scan_in;
         check_ff    <= check_in;
         xfs_ff      <= xfs_in;
         xbl_ff      <= xbl_in;
         xas_ff      <= xas_in;
         if (last_acc) begin
            ack_ff       <= ack_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // result payload, no reset needed
      if (last_acc) begin
         reply_ff       <= reply_in;
         reply_count_ff <= reply_count_in;
         exp_acks_ff    <= ack_in;
         start_ff       <= start_in;
         length_ff      <= length_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.reply         = reply_ff;
   assign rsp_ch.reply_count   = reply_count_ff;
   assign rsp_ch.expected_acks = exp_acks_ff;
   assign rsp_ch.frame_start   = start_ff;
   assign rsp_ch.frame_length  = length_ff;

   // a last byte always leaves a verdict in the result register
   `SEFC_ASSERT_NEXT(a_last_gives_result, clock, reset, last_acc, rsp_valid_ff,
                     "last byte accepted without a verdict")
   // frame location only accompanies an ACK
   `SEFC_ASSERT_NOW(a_nak_no_frame, clock, reset,
                    rsp_valid_ff && reply_ff != sefc_pkg::REPLY_ACK,
                    start_ff == '0 && length_ff == '0,
                    "frame location reported without ACK")
   // no reply means no reply characters
   `SEFC_ASSERT_NOW(a_none_no_count, clock, reset,
                    rsp_valid_ff && reply_ff == sefc_pkg::REPLY_NONE,
                    reply_count_ff == '0,
                    "reply count set with no reply")
   // position counter never passes its saturation point
   `SEFC_ASSERT_NOW(a_pos_bounded, clock, reset, 1'b1, pos_ff <= POS_MAX + POS_W'(1),
                    "byte position out of range")

endmodule

`default_nettype wire

[dv/sefc_verdict_checker.sv]
// Scoreboard for the STX/ETX frame checker: mirrors the burst scan and the
// verdict logic, and compares every verdict item field by field.
// Depends on sefc_pkg and the channel interfaces in sefc_if.sv.
module sefc_verdict_checker #(
   parameter int MAX_BURST = sefc_pkg::MAX_BURST_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   sefc_req_if                               req_mon,
   sefc_rsp_if                               rsp_mon,
   input  logic                              csr_we,
   input  logic [sefc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sefc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                pending_verdicts,
   output int                                verdicts_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      SCAN_SEARCH,
      SCAN_GOT_ETX,
      SCAN_GOT_LRC
   } scan_type;

   typedef struct packed {
      logic [sefc_pkg::REPLY_W-1:0]       reply;
      logic [sefc_pkg::COUNT_W-1:0]       reply_count;
      logic [sefc_pkg::COUNT_W-1:0]       expected_acks;
      logic [sefc_pkg::FRAME_START_W-1:0] frame_start;
      logic [sefc_pkg::FRAME_LEN_W-1:0]   frame_length;
   } verdict_type;

   // mode registers
   logic [sefc_pkg::MODE_W-1:0]        frame_mode_q;
   logic [sefc_pkg::MODE_W-1:0]        test_mode_q;

   // per-burst scan state
   logic [sefc_pkg::FRAME_LEN_W-1:0]   burst_pos;
   logic [sefc_pkg::BYTE_W-1:0]        first_byte_q;
   logic [sefc_pkg::BYTE_W-1:0]        prev_byte_q;
   logic [sefc_pkg::FRAME_START_W-1:0] stx_pos;
   logic                               stx_seen;
   logic [sefc_pkg::FRAME_START_W-1:0] etx_pos;
   scan_type                           scan;
   logic [sefc_pkg::BYTE_W-1:0]        check_byte;
   logic [sefc_pkg::BYTE_W-1:0]        xor_tail;
   logic [sefc_pkg::BYTE_W-1:0]        xor_tail_prev;
   logic [sefc_pkg::BYTE_W-1:0]        xor_frame;

   // kept across bursts
   logic [sefc_pkg::COUNT_W-1:0]       ack_count;

   verdict_type                        expected_verdicts[$];
   verdict_type                        want;
   int                                 errors = 0;
   int                                 checked = 0;

   function automatic void clear_burst();
      burst_pos     = '0;
      first_byte_q  = '0;
      prev_byte_q   = '0;
      stx_pos       = '0;
      stx_seen      = 1'b0;
      etx_pos       = '0;
      scan          = SCAN_SEARCH;
      check_byte    = '0;
      xor_tail      = '0;
      xor_tail_prev = '0;
      xor_frame     = '0;
   endfunction

   // Advance the scan by one byte; on the last byte of a burst queue the verdict.
   function automatic void predict_verdict_on_byte(input logic [sefc_pkg::BYTE_W-1:0] b,
                                                   input logic last);
      logic [sefc_pkg::FRAME_LEN_W-1:0] idx;
      logic [sefc_pkg::BYTE_W-1:0]      before_last;
      logic                             ok;
      int                               n;
      int                               start;
      int                               len;
      verdict_type                      v;
      idx         = burst_pos;
      before_last = prev_byte_q;
      ok          = 1'b0;
      start       = 0;
      len         = 0;
      v           = '0;
      v.reply     = sefc_pkg::REPLY_NAK;
      if (idx < MAX_BURST) begin
         if (idx == 0) begin
            first_byte_q = b;
         end else begin
            xor_tail_prev = xor_tail;
            xor_tail      = xor_tail ^ b;
         end
         if (scan == SCAN_SEARCH) begin
            if (b == sefc_pkg::STX_BYTE) begin
               stx_seen  = 1'b1;
               stx_pos   = idx[sefc_pkg::FRAME_START_W-1:0];
               xor_frame = '0;
            end else begin
               xor_frame = xor_frame ^ b;
               if (b == sefc_pkg::ETX_BYTE) begin
                  etx_pos = idx[sefc_pkg::FRAME_START_W-1:0];
                  scan    = SCAN_GOT_ETX;
               end
            end
         end else if (scan == SCAN_GOT_ETX) begin
            check_byte = b;
            scan       = SCAN_GOT_LRC;
         end
         prev_byte_q = b;
      end
      if (burst_pos <= MAX_BURST) burst_pos = burst_pos + 1'b1;
      if (!last) return;

      n = int'(burst_pos);
      if (test_mode_q == sefc_pkg::TEST_NO_REPLY) begin
         v.reply = sefc_pkg::REPLY_NONE;
      end else if (test_mode_q == sefc_pkg::TEST_ALWAYS_NAK
                   || frame_mode_q > sefc_pkg::FRAME_LRC) begin
         v.reply = sefc_pkg::REPLY_NAK;
      end else begin
         ack_count = (frame_mode_q == sefc_pkg::FRAME_PLAIN) ? sefc_pkg::ACKS_PLAIN
                                                             : sefc_pkg::ACKS_LRC;
         if (n >= 2 && n <= MAX_BURST) begin
            if (frame_mode_q == sefc_pkg::FRAME_PLAIN) begin
               if (first_byte_q == sefc_pkg::STX_BYTE && b == sefc_pkg::ETX_BYTE) begin
                  ok  = 1'b1;
                  len = n;
               end else if (stx_seen && scan != SCAN_SEARCH) begin
                  ok    = 1'b1;
                  start = int'(stx_pos);
                  len   = int'(etx_pos) - int'(stx_pos) + 1;
               end
            end else begin
               if (first_byte_q == sefc_pkg::STX_BYTE && before_last == sefc_pkg::ETX_BYTE) begin
                  ok  = (xor_tail_prev == b);
                  len = n;
               end else if (stx_seen && scan == SCAN_GOT_LRC) begin
                  ok    = (xor_frame == check_byte);
                  start = int'(stx_pos);
                  len   = int'(etx_pos) - int'(stx_pos) + 2;
               end
            end
         end
         v.reply = ok ? sefc_pkg::REPLY_ACK : sefc_pkg::REPLY_NAK;
      end
      if (ok) begin
         v.frame_start  = start[sefc_pkg::FRAME_START_W-1:0];
         v.frame_length = len[sefc_pkg::FRAME_LEN_W-1:0];
      end
      v.reply_count   = (v.reply == sefc_pkg::REPLY_NONE) ? '0 : ack_count;
      v.expected_acks = ack_count;
      expected_verdicts.push_back(v);
      clear_burst();
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] exp_val,
                                         input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         frame_mode_q = sefc_pkg::FRAME_PLAIN;
         test_mode_q  = '0;
         ack_count    = '0;
         clear_burst();
         expected_verdicts.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == sefc_pkg::REG_FRAME_MODE) frame_mode_q = csr_wdata;
            else if (csr_index == sefc_pkg::REG_TEST_MODE) test_mode_q = csr_wdata;
         end
         // a verdict leaves in a later cycle than its last byte, so pop before push
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict item arrived with no burst waiting for one");
               errors++;
            end else begin
               want = expected_verdicts.pop_front();
               compare_field("reply", 16'(want.reply), 16'(rsp_mon.reply));
               compare_field("reply_count", 16'(want.reply_count), 16'(rsp_mon.reply_count));
               compare_field("expected_acks", 16'(want.expected_acks),
                             16'(rsp_mon.expected_acks));
               compare_field("frame_start", 16'(want.frame_start), 16'(rsp_mon.frame_start));
               compare_field("frame_length", 16'(want.frame_length),
                             16'(rsp_mon.frame_length));
               checked++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_verdict_on_byte(req_mon.rx_byte, req_mon.end_of_burst);
      end
      fail_count       <= errors;
      pending_verdicts <= expected_verdicts.size();
      verdicts_checked <= checked;
   end

endmodule

[dv/testbench.sv]
// Top of the STX/ETX frame checker testbench: clock, reset, byte stimulus,
// result-side back-pressure, watchdog and the final verdict.
// Depends on sefc_pkg, sefc_if.sv, the RTL top and sefc_verdict_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int BURST_LIMIT     = sefc_pkg::MAX_BURST_DEFAULT;
   localparam int DRAIN_CYCLES    = 4;      // verdict register is one stage deep
   localparam int RSP_HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT  = 3000;   // cycles with no item moving at all

   // mode codes the package leaves unnamed
   localparam logic [sefc_pkg::MODE_W-1:0] FRAME_UNKNOWN  = 2'd2;
   localparam logic [sefc_pkg::MODE_W-1:0] FRAME_RESERVED = 2'd3;
   localparam logic [sefc_pkg::MODE_W-1:0] TEST_NORMAL    = 2'd0;
   localparam logic [sefc_pkg::MODE_W-1:0] TEST_RESERVED  = 2'd3;

   typedef enum int {
      LONG_NONE,
      LONG_OVER_LIMIT
   } long_burst_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [sefc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sefc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int verdicts_checked;

   // stimulus bookkeeping
   logic [sefc_pkg::BYTE_W-1:0] burst_bytes[$];
   int  items_sent    = 0;
   int  bursts_sent   = 0;
   int  settings_used = 0;
   int  stall_cycles  = 0;
   bit  no_idle       = 1'b0;   // both sides run flat out while set
   bit  rsp_hold_req  = 1'b0;   // ask the receiver for one long hold-off
   bit  rsp_hold_done = 1'b0;

   sefc_req_if byte_ch ();
   sefc_rsp_if verdict_ch ();

   stx_etx_frame_checker_lrc #(
      .MAX_BURST (BURST_LIMIT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (byte_ch),
      .rsp_ch    (verdict_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sefc_verdict_checker #(
      .MAX_BURST (BURST_LIMIT)
   ) i_verdict_chk (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (byte_ch),
      .rsp_mon          (verdict_ch),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_verdicts (pending),
      .verdicts_checked (verdicts_checked)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog: any accepted item on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (byte_ch.valid && byte_ch.ready) ||
          (verdict_ch.valid && verdict_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver: ready drops at random about 7 percent of the time, never while no_idle is set,
   // and once for a long stretch so the verdict register fills and the byte
   // input backs up while the sender keeps offering.
   initial begin
      verdict_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !rsp_hold_done) begin
            verdict_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_done = 1'b1;
         end else begin
            verdict_ch.ready <= no_idle || ($urandom_range(99) >= 7);
         end
      end
   end

   // any byte value except the two markers
   function automatic logic [sefc_pkg::BYTE_W-1:0] plain_byte();
      logic [sefc_pkg::BYTE_W-1:0] b;
      b = 8'($urandom_range(255));
      if (b == sefc_pkg::STX_BYTE || b == sefc_pkg::ETX_BYTE) b = b ^ 8'h80;
      return b;
   endfunction

   // random byte, markers heavily weighted
   function automatic logic [sefc_pkg::BYTE_W-1:0] noisy_byte();
      int p;
      p = $urandom_range(99);
      if (p < 10) return sefc_pkg::STX_BYTE;
      if (p < 20) return sefc_pkg::ETX_BYTE;
      return 8'($urandom_range(255));
   endfunction

   // One item. Valid stays high from item to item unless an idle cycle is drawn.
   task automatic send_item(input logic [sefc_pkg::BYTE_W-1:0] b, input logic last);
      while (!no_idle && $urandom_range(99) < 7) begin
         byte_ch.valid <= 1'b0;
         @(posedge clock);
      end
      byte_ch.valid        <= 1'b1;
      byte_ch.rx_byte      <= b;
      byte_ch.end_of_burst <= last;
      @(posedge clock);
      while (!byte_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_burst();
      for (int i = 0; i < burst_bytes.size(); i++)
         send_item(burst_bytes[i], i == burst_bytes.size() - 1);
      bursts_sent++;
   endtask

   // Drop valid, wait for every verdict to drain, then let the pipe settle.
   task automatic wait_idle();
      byte_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mode writes: only called with the block idle.
   task automatic set_modes(input logic [sefc_pkg::MODE_W-1:0] fmode,
                            input logic [sefc_pkg::MODE_W-1:0] tmode);
      csr_we    <= 1'b1;
      csr_index <= sefc_pkg::REG_FRAME_MODE;
      csr_wdata <= fmode;
      @(posedge clock);
      csr_index <= sefc_pkg::REG_TEST_MODE;
      csr_wdata <= tmode;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   // Random burst, mostly well-formed frames with random content.
   task automatic build_burst(input logic [sefc_pkg::MODE_W-1:0] fmode);
      int                          kind;
      logic [sefc_pkg::BYTE_W-1:0] b;
      logic [sefc_pkg::BYTE_W-1:0] lrc;
      burst_bytes.delete();
      kind = $urandom_range(99);
      lrc  = '0;
      if (kind < 70) begin
         // below 45: frame inside noise, otherwise a bare frame with noisy body
         if (kind < 45)
            repeat ($urandom_range(3))
               burst_bytes.push_back(($urandom_range(5) == 0) ? sefc_pkg::STX_BYTE
                                                               : plain_byte());
         burst_bytes.push_back(sefc_pkg::STX_BYTE);
         repeat ($urandom_range(12)) begin
            b   = (kind < 45) ? plain_byte() : noisy_byte();
            lrc = lrc ^ b;
            burst_bytes.push_back(b);
         end
         burst_bytes.push_back(sefc_pkg::ETX_BYTE);
         lrc = lrc ^ sefc_pkg::ETX_BYTE;
         // occasional single-bit LRC error
         if (fmode == sefc_pkg::FRAME_LRC)
            burst_bytes.push_back(($urandom_range(9) == 0) ?
                                  lrc ^ (8'h01 << $urandom_range(7)) : lrc);
         if (kind < 45 && $urandom_range(1) == 1)
            repeat ($urandom_range(3, 1)) burst_bytes.push_back(noisy_byte());
      end else if (kind < 85) begin
         // broken frame: plain loses its ETX, LRC mode never has an LRC byte and may lose its ETX
         if ($urandom_range(1) == 1) burst_bytes.push_back(plain_byte());
         burst_bytes.push_back(sefc_pkg::STX_BYTE);
         repeat ($urandom_range(6)) burst_bytes.push_back(plain_byte());
         burst_bytes.push_back(sefc_pkg::ETX_BYTE);
         if (fmode != sefc_pkg::FRAME_LRC || $urandom_range(1) == 1)
            void'(burst_bytes.pop_back());
      end else begin
         // pure noise, one byte up to sixteen
         repeat ($urandom_range(16, 1)) burst_bytes.push_back(noisy_byte());
      end
   endtask

   // One byte over the size bound, otherwise a whole plain frame: still NAK.
   task automatic build_long_burst();
      burst_bytes.delete();
      burst_bytes.push_back(sefc_pkg::STX_BYTE);
      repeat (BURST_LIMIT - 1) burst_bytes.push_back(plain_byte());
      burst_bytes.push_back(sefc_pkg::ETX_BYTE);
   endtask

   task automatic run_phase(input logic [sefc_pkg::MODE_W-1:0] fmode,
                            input logic [sefc_pkg::MODE_W-1:0] tmode,
                            input int budget, input bit quiet, input bit hold,
                            input long_burst_type long_kind);
      int sent_here;
      wait_idle();
      set_modes(fmode, tmode);
      no_idle <= quiet;
      if (hold) rsp_hold_req <= 1'b1;
      sent_here = 0;
      if (long_kind != LONG_NONE) begin
         build_long_burst();
         send_burst();
      end
      while (sent_here < budget) begin
         build_burst(fmode);
         sent_here += burst_bytes.size();
         send_burst();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      byte_ch.valid        <= 1'b0;
      byte_ch.rx_byte      <= '0;
      byte_ch.end_of_burst <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= sefc_pkg::REG_FRAME_MODE;
      csr_wdata            <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      // Test modes first, while the ack count still holds its reset value.
      set_modes(sefc_pkg::FRAME_PLAIN, sefc_pkg::TEST_ALWAYS_NAK);
      burst_bytes = '{sefc_pkg::STX_BYTE, sefc_pkg::ETX_BYTE};
      send_burst();
      wait_idle();
      set_modes(sefc_pkg::FRAME_PLAIN, sefc_pkg::TEST_NO_REPLY);
      burst_bytes = '{sefc_pkg::STX_BYTE, sefc_pkg::ETX_BYTE};
      send_burst();

      wait_idle();
      set_modes(sefc_pkg::FRAME_PLAIN, TEST_NORMAL);
      burst_bytes = '{sefc_pkg::STX_BYTE, 8'hFF, sefc_pkg::ETX_BYTE};     // whole frame
      send_burst();
      burst_bytes = '{sefc_pkg::ETX_BYTE};                                // one-byte burst
      send_burst();
      burst_bytes = '{sefc_pkg::STX_BYTE, sefc_pkg::STX_BYTE, 8'h11,
                      sefc_pkg::ETX_BYTE, 8'h00};                         // last STX wins
      send_burst();
      burst_bytes = '{sefc_pkg::STX_BYTE, 8'h55};                         // no ETX
      send_burst();

      wait_idle();
      set_modes(sefc_pkg::FRAME_LRC, TEST_NORMAL);
      burst_bytes = '{sefc_pkg::STX_BYTE, 8'h41, 8'h42, sefc_pkg::ETX_BYTE,
                      8'h41 ^ 8'h42 ^ sefc_pkg::ETX_BYTE};
      send_burst();
      burst_bytes = '{8'h00, sefc_pkg::STX_BYTE, sefc_pkg::ETX_BYTE};     // LRC byte missing
      send_burst();
      burst_bytes = '{sefc_pkg::STX_BYTE, 8'h41, sefc_pkg::ETX_BYTE, 8'h00}; // LRC mismatch
      send_burst();

      wait_idle();
      set_modes(FRAME_UNKNOWN, TEST_NORMAL);
      burst_bytes = '{sefc_pkg::STX_BYTE, sefc_pkg::ETX_BYTE};
      send_burst();

      // Random part: normal plain and LRC phases carry most of the traffic.
      // First phase runs with no idling, second one carries the long hold-off.
      run_phase(sefc_pkg::FRAME_PLAIN, TEST_NORMAL,              150, 1'b1, 1'b0, LONG_NONE);
      run_phase(sefc_pkg::FRAME_LRC,   TEST_NORMAL,              190, 1'b0, 1'b1, LONG_NONE);
      run_phase(sefc_pkg::FRAME_PLAIN, sefc_pkg::TEST_NO_REPLY,   40, 1'b0, 1'b0, LONG_NONE);
      run_phase(sefc_pkg::FRAME_LRC,   sefc_pkg::TEST_ALWAYS_NAK, 40, 1'b0, 1'b0, LONG_NONE);
      run_phase(FRAME_UNKNOWN,         TEST_NORMAL,               40, 1'b0, 1'b0, LONG_NONE);
      run_phase(FRAME_RESERVED,        TEST_RESERVED,             40, 1'b0, 1'b0, LONG_NONE);
      run_phase(sefc_pkg::FRAME_LRC,   TEST_RESERVED,            100, 1'b0, 1'b0, LONG_NONE);
      run_phase(sefc_pkg::FRAME_PLAIN, sefc_pkg::TEST_ALWAYS_NAK, 30, 1'b0, 1'b0, LONG_NONE);
      run_phase(FRAME_UNKNOWN,         sefc_pkg::TEST_NO_REPLY,   30, 1'b0, 1'b0, LONG_NONE);
      run_phase(sefc_pkg::FRAME_PLAIN, TEST_NORMAL,               80, 1'b0, 1'b0,
                LONG_OVER_LIMIT);

      // drain: the watchdog bounds this wait
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d bytes in %0d bursts over %0d mode settings, %0d verdicts compared.",
               items_sent, bursts_sent, settings_used, verdicts_checked);
      $display("Bursts spanned one byte to one past the %0d-byte bound; one %0d-cycle stall.",
               BURST_LIMIT, RSP_HOLD_CYCLES);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/sefc_pkg.sv
sv/sefc_if.sv
sv/stx_etx_frame_checker_lrc.sv
dv/sefc_verdict_checker.sv
dv/testbench.sv
